FILE: rtl/core/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg: stereo correlation meter shared definitions
// Widths, register indexes, payload structs and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COEF_BITS     = 16;
   localparam int AVG_BITS      = 48;
   localparam int PROD_BITS     = 2 * SAMPLE_BITS;
   localparam int POW_BITS      = AVG_BITS - 1 - COEF_BITS;
   localparam int RAD_BITS      = 2 * POW_BITS;
   localparam int ROOT_BITS     = POW_BITS;
   localparam int FLOOR_BITS    = 31;
   localparam int CORR_BITS     = 16;
   localparam int CSR_DATA_BITS = FLOOR_BITS;
   localparam int CSR_IDX_BITS  = 1;

   localparam int SQRT_STEPS    = RAD_BITS / 2;
   localparam int DIV_STEPS     = CORR_BITS;
   localparam int STEP_BITS     = $clog2(SQRT_STEPS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SMOOTH = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLOOR  = 1'b1;

   localparam logic [COEF_BITS-1:0]  SMOOTH_RESET = 16'd33;
   localparam logic [FLOOR_BITS-1:0] FLOOR_RESET  = 31'd1074;
   localparam logic [CORR_BITS-1:0]  CORR_MAX     = 16'd32767;

   typedef enum logic [1:0] {
      CH_LEFT  = 2'd0,
      CH_RIGHT = 2'd1,
      CH_CROSS = 2'd2
   } chan_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [CORR_BITS-1:0] correlation;
      logic                        below_floor;
   } rsp_type;

   typedef struct packed {
      logic     load_in;
      logic     sm_mul;
      logic     sm_scale;
      logic     sm_acc;
      chan_type ch;
      logic     root_mul;
      logic     sqrt_step;
      logic     div_init;
      logic     div_step;
      logic     out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic floor_hit;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/scm_dp.sv
// ----------------------------------------------------------------------------
// scm_dp: stereo correlation meter datapath
// Power/cross smoothing with one shared multiply path, a bit-serial integer
// square root, a restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_dp import scm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  req_type                  req_data,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output rsp_type                  rsp_data
);

   localparam int LO_BITS   = AVG_BITS / 2;
   localparam int HI_BITS   = AVG_BITS - LO_BITS;
   localparam int FULL_BITS = AVG_BITS + COEF_BITS;
   localparam int SUM_BITS  = AVG_BITS + 2;
   localparam int DVS_BITS  = ROOT_BITS + 1;

   localparam logic signed [AVG_BITS-1:0] AVG_MAX = {1'b0, {(AVG_BITS-1){1'b1}}};
   localparam logic signed [AVG_BITS-1:0] AVG_MIN = {1'b1, {(AVG_BITS-1){1'b0}}};

   // configuration
   logic [COEF_BITS-1:0]  alpha_ff, alpha_in;
   logic [FLOOR_BITS-1:0] floor_ff, floor_in;

   // smoothing
   logic signed [SAMPLE_BITS-1:0]        left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0]        right_ff, right_in;
   logic signed [AVG_BITS-1:0]           avg_ff [3];
   logic signed [AVG_BITS-1:0]           avg_in;
   logic signed [PROD_BITS-1:0]          prod_ff, prod_in;
   logic [LO_BITS+COEF_BITS-1:0]         plo_ff, plo_in;
   logic signed [HI_BITS+COEF_BITS:0]    phi_ff, phi_in;
   logic signed [PROD_BITS+COEF_BITS:0]  pa_ff, pa_in;
   logic signed [AVG_BITS-1:0]           decay_ff, decay_in;

   logic signed [SAMPLE_BITS-1:0] op_a, op_b;
   logic signed [AVG_BITS-1:0]    avg_sel;
   logic signed [COEF_BITS:0]     alpha_s;
   logic signed [FULL_BITS-1:0]   full_prod;
   logic signed [SUM_BITS-1:0]    sum;

   // square root
   logic [RAD_BITS-1:0] rad_ff, rad_in;
   logic [RAD_BITS-1:0] res_ff, res_in;
   logic [RAD_BITS-1:0] bit_ff, bit_in;
   logic [POW_BITS-1:0] pow_l, pow_r;
   logic [RAD_BITS:0]   trial;
   logic                take;
   logic [ROOT_BITS-1:0] root;

   // division
   logic [AVG_BITS-1:0]  rem_ff, rem_in;
   logic [AVG_BITS-1:0]  dsh_ff, dsh_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic                 sat_ff, sat_in;
   logic                 below_ff, below_in;
   logic [AVG_BITS-1:0]  cross_u, mag;
   logic [DVS_BITS-1:0]  divisor;
   logic                 ge;
   logic [CORR_BITS-1:0] qsat;

   rsp_type rsp_ff, rsp_in;

   // ---------------- configuration ----------------
   always_comb begin
      alpha_in = alpha_ff;
      floor_in = floor_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SMOOTH: alpha_in = csr_wdata[COEF_BITS-1:0];
            CSR_FLOOR:  floor_in = csr_wdata[FLOOR_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // ---------------- smoothing ----------------
   assign op_a    = (cmd.ch == CH_RIGHT) ? right_ff : left_ff;
   assign op_b    = (cmd.ch == CH_LEFT) ? left_ff : right_ff;
   assign avg_sel = avg_ff[cmd.ch];
   assign alpha_s = signed'({1'b0, alpha_ff});

   // avg * alpha rebuilt from two partial products
   assign full_prod = (FULL_BITS'(phi_ff) <<< LO_BITS) + signed'(FULL_BITS'(plo_ff));
   assign sum = SUM_BITS'(avg_sel) - SUM_BITS'(decay_ff) + SUM_BITS'(pa_ff);

   always_comb begin
      left_in  = cmd.load_in ? req_data.left_sample : left_ff;
      right_in = cmd.load_in ? req_data.right_sample : right_ff;
      prod_in  = prod_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      pa_in    = pa_ff;
      decay_in = decay_ff;
      if (cmd.sm_mul) begin
         prod_in = op_a * op_b;
         plo_in  = avg_sel[LO_BITS-1:0] * alpha_ff;
         phi_in  = signed'(avg_sel[AVG_BITS-1:LO_BITS]) * alpha_s;
      end
      if (cmd.sm_scale) begin
         pa_in    = prod_ff * alpha_s;
         decay_in = full_prod[FULL_BITS-1:COEF_BITS];
      end
      // saturate to the state range
      if (!sum[SUM_BITS-1] && (|sum[SUM_BITS-2:AVG_BITS-1])) begin
         avg_in = AVG_MAX;
      end else if (sum[SUM_BITS-1] && !(&sum[SUM_BITS-2:AVG_BITS-1])) begin
         avg_in = AVG_MIN;
      end else begin
         avg_in = sum[AVG_BITS-1:0];
      end
   end

   // ---------------- square root ----------------
   assign pow_l = avg_ff[CH_LEFT][AVG_BITS-1] ? '0 : avg_ff[CH_LEFT][AVG_BITS-2:COEF_BITS];
   assign pow_r = avg_ff[CH_RIGHT][AVG_BITS-1] ? '0 : avg_ff[CH_RIGHT][AVG_BITS-2:COEF_BITS];
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign take  = ({1'b0, rad_ff} >= trial);
   assign root  = res_ff[ROOT_BITS-1:0];

   always_comb begin
      rad_in = rad_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (cmd.root_mul) begin
         rad_in = pow_l * pow_r;
         res_in = '0;
         bit_in = RAD_BITS'(1) << (RAD_BITS - 2);
      end else if (cmd.sqrt_step) begin
         if (take) begin
            rad_in = rad_ff - trial[RAD_BITS-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   assign status.floor_hit = (root == '0) || (root < floor_ff);

   // ---------------- division ----------------
   assign cross_u = avg_ff[CH_CROSS];
   assign mag     = cross_u[AVG_BITS-1] ? (~cross_u + AVG_BITS'(1)) : cross_u;
   assign divisor = {root, 1'b0};
   assign ge      = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      below_in = below_ff;
      if (cmd.div_init) begin
         rem_in   = mag;
         dsh_in   = AVG_BITS'({divisor, {(DIV_STEPS-1){1'b0}}});
         q_in     = '0;
         neg_in   = cross_u[AVG_BITS-1];
         sat_in   = ({1'b0, mag} >= (AVG_BITS+1)'({divisor, {DIV_STEPS{1'b0}}}));
         below_in = status.floor_hit;
      end else if (cmd.div_step) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[DIV_STEPS-2:0], ge};
         dsh_in = dsh_ff >> 1;
      end
   end

   // ---------------- result ----------------
   assign qsat = (sat_ff || q_ff[DIV_STEPS-1]) ? CORR_MAX : q_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         if (below_ff) begin
            rsp_in.correlation = '0;
            rsp_in.below_floor = 1'b1;
         end else begin
            rsp_in.correlation = neg_ff ? signed'(-qsat) : signed'(qsat);
            rsp_in.below_floor = 1'b0;
         end
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= SMOOTH_RESET;
         floor_ff <= FLOOR_RESET;
         for (int i = 0; i < 3; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         alpha_ff <= alpha_in;
         floor_ff <= floor_in;
         if (cmd.sm_acc) begin
            avg_ff[cmd.ch] <= avg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      prod_ff  <= prod_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      pa_ff    <= pa_in;
      decay_ff <= decay_in;
      rad_ff   <= rad_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
      sat_ff   <= sat_in;
      below_ff <= below_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl: stereo correlation meter controller
// Sequences smoothing, square root and division per beat and owns the
// request/response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl import scm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SM_MUL   = 9'b000000010,
      ST_SM_SCALE = 9'b000000100,
      ST_SM_ACC   = 9'b000001000,
      ST_ROOT_MUL = 9'b000010000,
      ST_SQRT     = 9'b000100000,
      ST_CHECK    = 9'b001000000,
      ST_DIV      = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   chan_type              ch_ff, ch_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.ch   = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               ch_in       = CH_LEFT;
               state_in    = ST_SM_MUL;
            end
         end
         ST_SM_MUL: begin
            cmd.sm_mul = 1'b1;
            state_in   = ST_SM_SCALE;
         end
         ST_SM_SCALE: begin
            cmd.sm_scale = 1'b1;
            state_in     = ST_SM_ACC;
         end
         ST_SM_ACC: begin
            cmd.sm_acc = 1'b1;
            unique case (ch_ff)
               CH_LEFT:  begin ch_in = CH_RIGHT; state_in = ST_SM_MUL;   end
               CH_RIGHT: begin ch_in = CH_CROSS; state_in = ST_SM_MUL;   end
               default:  begin ch_in = CH_LEFT;  state_in = ST_ROOT_MUL; end
            endcase
         end
         ST_ROOT_MUL: begin
            cmd.root_mul = 1'b1;
            step_in      = '0;
            state_in     = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SQRT_STEPS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            // skip the divide when the root is zero or under the floor
            state_in     = status.floor_hit ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= CH_LEFT;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/stereo_correlation_meter_top.sv
// ----------------------------------------------------------------------------
// stereo_correlation_meter_top: stereo correlation meter top level
// Takes one beat at a time: req_ready is low from an accepted request beat
// until its result is loaded into the response register. The 31-step square
// root and the 16-step divider share one controller sequence with the
// smoothing; the divide is skipped when the root is zero or under the floor.
// Reset: synchronous; averages clear, coefficient 33, floor 1074.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_correlation_meter_top import scm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   scm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   scm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.below_floor |-> rsp_data.correlation == '0)
      else $error("below_floor set with nonzero correlation");

   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.correlation != 16'sh8000)
      else $error("correlation outside clamp range");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is in progress");

endmodule

`default_nettype wire

FILE: tb/tb_stereo_correlation_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_correlation_meter_top: stereo correlation meter testbench
// Drives left/right sample beats through a directed table and then through
// random phases under several smoothing and floor settings. Every beat is
// scored against a known-row value or an in-bench model of the smoothed
// powers, root and clamped quotient. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_stereo_correlation_meter_top;
   import scm_pkg::*;

   localparam longint AVG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint AVG_MIN = -AVG_MAX - 1;
   localparam int     PHASE_BEATS = 235;
   localparam int     PRINT_LIMIT = 100;

   typedef enum logic [1:0] {
      ROW_PAIR  = 2'd0,
      ROW_KNOWN = 2'd1,
      ROW_CSR   = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_IDX_BITS-1:0]    index;
      logic [CSR_DATA_BITS-1:0]   value;
      req_type                    pair;
      rsp_type                    want;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // model state and registers
   longint                   left_pow = 0;
   longint                   right_pow = 0;
   longint                   cross_pow = 0;
   logic [COEF_BITS-1:0]     meter_coef = SMOOTH_RESET;
   logic [FLOOR_BITS-1:0]    meter_floor = FLOOR_RESET;

   rsp_type                  expected_corr [$];
   plan_row_type             stimulus_plan [$];
   int                       fail_count = 0;
   int                       rsp_beats = 0;
   int                       rsp_beats_seen = 0;
   int                       rsp_hold = 0;
   bit                       rsp_quiet = 1'b0;
   bit                       send_quiet = 1'b0;
   rsp_type                  corr_want;

   stereo_correlation_meter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #20_000_000;
      $display("stereo_correlation_meter_top verification failed");
      $finish;
   end

   function automatic longint smooth_avg(longint avg, longint prod, longint alpha);
      longint n;
      n = avg - ((avg * alpha) >>> COEF_BITS) + prod * alpha;
      if (n > AVG_MAX) n = AVG_MAX;
      if (n < AVG_MIN) n = AVG_MIN;
      return n;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x = x - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type predict_correlation(req_type pair);
      longint          l;
      longint          r;
      longint          alpha;
      longint          corr;
      longint unsigned pl;
      longint unsigned pr;
      longint unsigned root;
      longint unsigned mag;
      bit              neg;
      rsp_type         res;
      l = longint'($signed(pair.left_sample));
      r = longint'($signed(pair.right_sample));
      alpha = longint'({48'd0, meter_coef});
      left_pow = smooth_avg(left_pow, l * l, alpha);
      right_pow = smooth_avg(right_pow, r * r, alpha);
      cross_pow = smooth_avg(cross_pow, l * r, alpha);
      pl = (left_pow > 0) ? (left_pow >> COEF_BITS) : 0;
      pr = (right_pow > 0) ? (right_pow >> COEF_BITS) : 0;
      root = int_sqrt(pl * pr);
      res = '0;
      // zero root counts as under the floor even when the floor is zero
      if (root == 0 || root < meter_floor) begin
         res.below_floor = 1'b1;
         return res;
      end
      neg = cross_pow < 0;
      mag = neg ? -cross_pow : cross_pow;
      mag = mag / (root << 1);
      if (mag > CORR_MAX) mag = CORR_MAX;
      corr = neg ? -longint'(mag) : longint'(mag);
      res.correlation = corr[CORR_BITS-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (fail_count < PRINT_LIMIT)
         $display("mismatch on %s at beat %0d: got %0d, expected %0d",
                  what, rsp_beats, got, want);
      fail_count++;
   endtask

   function automatic void add_pair(int l, int r);
      plan_row_type row;
      row = '0;
      row.kind = ROW_PAIR;
      row.pair.left_sample = l[SAMPLE_BITS-1:0];
      row.pair.right_sample = r[SAMPLE_BITS-1:0];
      stimulus_plan.push_back(row);
   endfunction

   function automatic void add_known(int l, int r, int corr, bit flag);
      plan_row_type row;
      row = '0;
      row.kind = ROW_KNOWN;
      row.pair.left_sample = l[SAMPLE_BITS-1:0];
      row.pair.right_sample = r[SAMPLE_BITS-1:0];
      row.want.correlation = corr[CORR_BITS-1:0];
      row.want.below_floor = flag;
      stimulus_plan.push_back(row);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] value);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.index = index;
      row.value = value;
      stimulus_plan.push_back(row);
   endfunction

   // Enter and leave at a falling edge; valid stays high only when the
   // next beat follows without a gap.
   task automatic send_pair(input req_type pair, input bit known, input rsp_type want);
      rsp_type guess;
      int      gap;
      req_valid <= 1'b1;
      req_data <= pair;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_correlation(pair);
      expected_corr.push_back(known ? want : guess);
      @(negedge clock);
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and hold until every outstanding beat has returned.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_corr.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_SMOOTH: meter_coef = value[COEF_BITS-1:0];
         CSR_FLOOR:  meter_floor = value[FLOOR_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // count the stall only while a response beat is waiting
   always @(negedge clock) begin
      if (rsp_beats != rsp_beats_seen) begin
         rsp_beats_seen = rsp_beats;
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 11);
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         if (rsp_valid) rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : score
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats++;
         if (expected_corr.size() == 0) begin
            report_mismatch("unexpected beat", $signed(rsp_data.correlation), 0);
         end else begin
            corr_want = expected_corr.pop_front();
            if (rsp_data.correlation !== corr_want.correlation)
               report_mismatch("correlation", $signed(rsp_data.correlation),
                               $signed(corr_want.correlation));
            if (rsp_data.below_floor !== corr_want.below_floor)
               report_mismatch("below_floor", rsp_data.below_floor,
                               corr_want.below_floor);
         end
      end
   end

   initial begin : stimulus
      logic signed [SAMPLE_BITS-1:0] corner [5];
      logic signed [SAMPLE_BITS-1:0] l16;
      logic signed [SAMPLE_BITS-1:0] r16;
      logic [COEF_BITS-1:0]          coef;
      logic [FLOOR_BITS-1:0]         floor_value;
      req_type                       pair;
      int                            shape;

      corner[0] = -16'sd32768;
      corner[1] = 16'sd32767;
      corner[2] = 16'sd0;
      corner[3] = -16'sd1;
      corner[4] = 16'sd1;
      shape = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // silence after reset gives a zero root
      add_known(0, 0, 0, 1'b1);
      // full scale in phase: quotient lands just past one and clamps
      add_known(32767, 32767, 32767, 1'b0);
      add_pair(-32768, -32768);
      add_pair(-32768, 32767);
      add_pair(32767, -32768);
      add_pair(0, 32767);
      add_pair(32767, 0);
      add_pair(1, -1);
      add_pair(21845, -21846);
      // fastest smoothing: drive toward minus one
      add_csr(CSR_SMOOTH, 31'd65535);
      add_pair(32767, -32768);
      add_pair(32767, -32768);
      add_pair(32767, -32768);
      add_pair(-32768, -32768);
      // zero coefficient freezes the averages
      add_csr(CSR_SMOOTH, 31'd0);
      add_pair(100, -200);
      add_pair(-32768, 32767);
      // upper data bits are ignored by the coefficient register
      add_csr(CSR_SMOOTH, 31'h7FFF_FFFF);
      add_csr(CSR_FLOOR, 31'd0);
      // right power decays to a zero root against a zero floor
      add_pair(1000, 0);
      add_pair(1000, 0);
      add_pair(1000, 0);
      add_pair(1000, 0);
      add_csr(CSR_FLOOR, 31'h7FFF_FFFF);
      add_known(-32768, 32767, 0, 1'b1);
      add_pair(-32768, -32768);
      add_csr(CSR_FLOOR, 31'(FLOOR_RESET));
      add_csr(CSR_SMOOTH, 31'd1);
      add_pair(0, 0);

      foreach (stimulus_plan[i]) begin
         case (stimulus_plan[i].kind)
            ROW_CSR: begin
               settle();
               write_csr(stimulus_plan[i].index, stimulus_plan[i].value);
            end
            ROW_KNOWN: send_pair(stimulus_plan[i].pair, 1'b1, stimulus_plan[i].want);
            default:   send_pair(stimulus_plan[i].pair, 1'b0, '0);
         endcase
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin coef = SMOOTH_RESET; floor_value = FLOOR_RESET; end
            1: begin coef = 16'd65535; floor_value = '0; end
            2: begin coef = 16'd4096; floor_value = FLOOR_RESET; end
            3: begin
               coef = 16'($urandom_range(1, 65535));
               floor_value = 31'($urandom_range(0, 32'h0010_0000));
            end
            4: begin coef = 16'd512; floor_value = 31'h7FFF_FFFF; end
            5: begin
               coef = 16'($urandom_range(1, 65535));
               floor_value = 31'($urandom_range(0, 32'h4000_0000));
            end
            6: begin coef = 16'd1; floor_value = '0; end
            default: begin coef = 16'd20000; floor_value = FLOOR_RESET; end
         endcase
         settle();
         write_csr(CSR_SMOOTH, {15'($urandom), coef});
         write_csr(CSR_FLOOR, floor_value);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            // hold one signal shape over a run of beats so the averages settle
            if (n % 32 == 0) shape = $urandom_range(0, 9);
            if ($urandom_range(0, 59) == 0) settle();
            l16 = 16'($urandom);
            r16 = 16'($urandom);
            case (shape)
               3: r16 = l16;
               4: r16 = -l16;
               5: begin
                  l16 = 16'($signed($urandom_range(0, 63)) - 32);
                  r16 = 16'($signed($urandom_range(0, 63)) - 32);
               end
               6: begin
                  l16 = corner[$urandom_range(0, 4)];
                  r16 = corner[$urandom_range(0, 4)];
               end
               7: r16 = '0;
               8: l16 = '0;
               9: r16 = l16 >>> 1;
               default: ;
            endcase
            pair.left_sample = l16;
            pair.right_sample = r16;
            send_pair(pair, 1'b0, '0);
         end
      end

      settle();
      repeat (70) @(negedge clock);
      if (fail_count == 0)
         $display("stereo_correlation_meter_top verification clean");
      else
         $display("stereo_correlation_meter_top verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/scm_pkg.sv
rtl/core/scm_dp.sv
rtl/core/scm_ctrl.sv
rtl/core/stereo_correlation_meter_top.sv
tb/tb_stereo_correlation_meter_top.sv
